// ===== hdl/ptc_pkg.sv =====
// Shared types and constants for the pressure and temperature compensation pipeline.
package ptc_pkg;

    localparam int C_DIV_STEPS = 64;

    localparam logic [1:0] C_REG_TEMP    = 2'd0;
    localparam logic [1:0] C_REG_PRESS_A = 2'd1;
    localparam logic [1:0] C_REG_PRESS_B = 2'd2;
    localparam logic [1:0] C_REG_PRESS_C = 2'd3;

    localparam logic signed [33:0] C_T_OFFSET = 34'sd128000;
    localparam logic [11:0]        C_P_SCALE  = 12'd3125;
    localparam logic [20:0]        C_P_BASE   = 21'd1048576;
    localparam logic [63:0]        C_P_BIAS   = 64'd1 << 47;

    typedef struct packed {
        logic        ok;
        logic        neg;
        logic [31:0] tc;
    } t_tag;

endpackage

// ===== hdl/pressure_temperature_compensation.sv =====
// Top level: calibrated temperature and pressure from raw barometric readings.
// Throughput: one item per cycle; o_busy stays low, results are never held off.
// The 64-stage divider, one quotient bit per stage, sets most of the latency.
// Reset clears the calibration registers and all stage valid bits.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [19:0]        i_raw_pressure,
    input  logic [19:0]        i_raw_temperature,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    output logic               o_strobe,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_result_valid
);

    logic [47:0] r_tco, r_pca, r_pcb, r_pcc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tco <= '0;
            r_pca <= '0;
            r_pcb <= '0;
            r_pcc <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_TEMP:    r_tco <= i_cfg_data;
                C_REG_PRESS_A: r_pca <= i_cfg_data;
                C_REG_PRESS_B: r_pcb <= i_cfg_data;
                C_REG_PRESS_C: r_pcc <= i_cfg_data;
                default:       r_tco <= r_tco;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = r_tco[15:0];
    assign t2 = $signed(r_tco[31:16]);
    assign t3 = $signed(r_tco[47:32]);
    assign p1 = r_pca[15:0];
    assign p2 = $signed(r_pca[31:16]);
    assign p3 = $signed(r_pca[47:32]);
    assign p4 = $signed(r_pcb[15:0]);
    assign p5 = $signed(r_pcb[31:16]);
    assign p6 = $signed(r_pcb[47:32]);
    assign p7 = $signed(r_pcc[15:0]);
    assign p8 = $signed(r_pcc[31:16]);
    assign p9 = $signed(r_pcc[47:32]);

    assign o_busy = 1'b0;

    logic [11:1] r_vp;
    logic [19:0] r_adcp [1:8];
    logic [31:0] r_tc   [6:11];

    logic signed [18:0] r_d1;
    logic signed [17:0] r_d2;
    logic signed [34:0] r_m1;
    logic signed [35:0] r_sq;
    logic signed [23:0] r_a1;
    logic signed [39:0] r_m2;
    logic signed [31:0] r_fine;
    logic signed [33:0] r_v1;
    logic [63:0]        r_vsq;
    logic signed [49:0] r_vp5_6, r_vp2_6, r_vp5_7, r_vp2_7;
    logic [63:0]        r_x6, r_x3, r_v2, r_v1n, r_prod, r_numa, r_num;
    logic signed [30:0] r_v1f;
    logic [63:0]        r_mn;
    logic [31:0]        r_md;
    t_tag               r_tag11;

    logic signed [18:0] n_d1;
    logic signed [17:0] n_d2;
    logic signed [39:0] n_fsum, n_tc;
    logic signed [67:0] n_sqf;
    logic signed [79:0] n_x6, n_x3;
    logic [79:0]        n_prod, n_num;
    logic [20:0]        n_p;
    logic signed [31:0] n_v1fx;

    assign n_d1   = $signed({2'b00, i_raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
    assign n_d2   = $signed({2'b00, i_raw_temperature[19:4]}) - $signed({2'b00, t1});
    assign n_fsum = 40'(r_a1) + (r_m2 >>> 14);
    assign n_tc   = 40'(r_fine) * 40'sd5 + 40'sd128;
    assign n_sqf  = r_v1 * r_v1;
    assign n_x6   = $signed(r_vsq) * p6;
    assign n_x3   = $signed(r_vsq) * p3;
    assign n_prod = (C_P_BIAS + r_v1n) * p1;
    assign n_p    = C_P_BASE - {1'b0, r_adcp[8]};
    assign n_num  = r_numa * C_P_SCALE;
    assign n_v1fx = 32'(r_v1f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else begin
            r_vp <= {r_vp[10:1], i_start & ~o_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_adcp[1] <= i_raw_pressure;
        for (int i = 2; i <= 8; i++) begin
            r_adcp[i] <= r_adcp[i-1];
        end
        for (int i = 7; i <= 11; i++) begin
            r_tc[i] <= r_tc[i-1];
        end
        r_d1    <= n_d1;
        r_d2    <= n_d2;
        r_m1    <= r_d1 * t2;
        r_sq    <= r_d2 * r_d2;
        r_a1    <= 24'(r_m1 >>> 11);
        r_m2    <= (r_sq >>> 12) * t3;
        r_fine  <= n_fsum[31:0];
        r_tc[6] <= n_tc[39:8];
        r_v1    <= 34'(r_fine) - C_T_OFFSET;
        r_vsq   <= n_sqf[63:0];
        r_vp5_6 <= r_v1 * p5;
        r_vp2_6 <= r_v1 * p2;
        r_x6    <= n_x6[63:0];
        r_x3    <= n_x3[63:0];
        r_vp5_7 <= r_vp5_6;
        r_vp2_7 <= r_vp2_6;
        r_v2    <= r_x6 + (64'(r_vp5_7) << 17) + (64'(p4) << 35);
        r_v1n   <= 64'($signed(r_x3) >>> 8) + (64'(r_vp2_7) << 12);
        r_prod  <= n_prod[63:0];
        r_numa  <= (64'(n_p) << 31) - r_v2;
        r_v1f   <= $signed(r_prod[63:33]);
        r_num   <= n_num[63:0];
        r_mn    <= r_num[63] ? 64'(-r_num) : r_num;
        r_md    <= r_v1f[30] ? 32'(-n_v1fx) : n_v1fx;
        r_tag11 <= '{ok: (r_v1f != '0), neg: r_num[63] ^ r_v1f[30], tc: r_tc[11]};
    end

    logic        div_vld;
    logic [63:0] div_quo;
    t_tag        div_tag;

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vp[11]),
        .i_num   (r_mn),
        .i_den   (r_md),
        .i_tag   (r_tag11),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_tag   (div_tag)
    );

    logic [4:0]  r_vq;
    t_tag        r_tq [0:3];
    logic [63:0] r_q  [0:3];
    logic [63:0] r_hlhl, r_vq8, r_hsq, r_x9;
    logic [31:0] r_hhhl;
    logic [63:0] r_v2p_2, r_v2p_3;

    logic [63:0]        n_h;
    logic signed [79:0] n_vq8, n_x9;
    logic [63:0]        n_sum;
    logic [31:0]        n_pout;

    assign n_h   = $signed(r_q[0]) >>> 13;
    assign n_vq8 = $signed(r_q[0]) * p8;
    assign n_x9  = $signed(r_hsq) * p9;
    assign n_sum = r_q[3] + 64'($signed(r_x9) >>> 25) + r_v2p_3;
    assign n_pout = n_sum[39:8] + 32'(32'(p7) << 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= '0;
        end else begin
            r_vq <= {r_vq[3:0], div_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0]  <= div_tag.neg ? 64'(-div_quo) : div_quo;
        r_tq[0] <= div_tag;
        for (int i = 1; i <= 3; i++) begin
            r_q[i]  <= r_q[i-1];
            r_tq[i] <= r_tq[i-1];
        end
        r_hlhl  <= n_h[31:0] * n_h[31:0];
        r_hhhl  <= 32'(n_h[63:32] * n_h[31:0]);
        r_vq8   <= n_vq8[63:0];
        r_hsq   <= r_hlhl + {r_hhhl[30:0], 33'b0};
        r_v2p_2 <= $signed(r_vq8) >>> 19;
        r_x9    <= n_x9[63:0];
        r_v2p_3 <= r_v2p_2;
        o_temperature_centi <= r_tq[3].ok ? $signed(r_tq[3].tc) : '0;
        o_pressure_q24_8    <= r_tq[3].ok ? n_pout : '0;
        o_result_valid      <= r_tq[3].ok;
    end

    assign o_strobe = r_vq[4];

endmodule

// ===== hdl/ptc_div.sv =====
// Pipelined unsigned 64 by 32 bit divider, one quotient bit per stage.
module ptc_div
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    input  t_tag        i_tag,
    output logic        o_vld,
    output logic [63:0] o_quo,
    output t_tag        o_tag
);

    logic        r_vld [1:C_DIV_STEPS];
    logic [63:0] r_dq  [1:C_DIV_STEPS];
    logic [31:0] r_rem [1:C_DIV_STEPS];
    logic [31:0] r_den [1:C_DIV_STEPS];
    t_tag        r_tag [1:C_DIV_STEPS];

    for (genvar gi = 0; gi < C_DIV_STEPS; gi++) begin : g_step
        logic        vld_in;
        logic [63:0] dq_in;
        logic [31:0] rem_in;
        logic [31:0] den_in;
        t_tag        tag_in;
        logic [32:0] n_trial;
        logic        n_ge;

        if (gi == 0) begin : g_first
            assign vld_in = i_vld;
            assign dq_in  = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
            assign tag_in = i_tag;
        end else begin : g_next
            assign vld_in = r_vld[gi];
            assign dq_in  = r_dq[gi];
            assign rem_in = r_rem[gi];
            assign den_in = r_den[gi];
            assign tag_in = r_tag[gi];
        end

        assign n_trial = {rem_in, dq_in[63]};
        assign n_ge    = n_trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi+1] <= 1'b0;
            end else begin
                r_vld[gi+1] <= vld_in;
            end
            r_rem[gi+1] <= n_ge ? 32'(n_trial - {1'b0, den_in}) : n_trial[31:0];
            r_dq[gi+1]  <= {dq_in[62:0], n_ge};
            r_den[gi+1] <= den_in;
            r_tag[gi+1] <= tag_in;
        end
    end

    assign o_vld = r_vld[C_DIV_STEPS];
    assign o_quo = r_dq[C_DIV_STEPS];
    assign o_tag = r_tag[C_DIV_STEPS];

endmodule
